FILE: rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// Lottery slot picker package
// Shared field widths, stream layout, item kinds and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsp_pkg;

    // Field widths of one input item and one result item.
    localparam int SLOT_W  = 6;
    localparam int TIX_W   = 10;
    localparam int DRAW_W  = 17;
    localparam int TOT_W   = 16;
    localparam int DCNT_W  = 5;

    // Input tdata layout: slot, runnable, ticket_count, random_draw.
    localparam int IN_SLOT_LSB = 0;
    localparam int IN_RUN_LSB  = IN_SLOT_LSB + SLOT_W;
    localparam int IN_TIX_LSB  = IN_RUN_LSB + 1;
    localparam int IN_DRAW_LSB = IN_TIX_LSB + TIX_W;
    localparam int IN_USED_W   = IN_DRAW_LSB + DRAW_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout: chosen_slot, found, total_held.
    localparam int OUT_SLOT_LSB  = 0;
    localparam int OUT_FOUND_LSB = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_TOT_LSB   = OUT_FOUND_LSB + 1;
    localparam int OUT_USED_W    = OUT_TOT_LSB + TOT_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // Item kinds carried on tuser.
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_DRAW   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic upd_wr;
        logic start;
        logic sum_en;
        logic div_init;
        logic div_step;
        logic walk_init;
        logic walk_en;
        logic out_load;
    } lsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic total_zero;
        logic div_last;
        logic hit;
    } lsp_sts_t;

endpackage

FILE: rtl/lottery_slot_picker.sv
// ----------------------------------------------------------------------------
// Lottery slot picker
// Lottery scheduling over a table of slots with ticket counts and runnable
// flags.
// ----------------------------------------------------------------------------
// An update item (tuser 0) writes one slot's ticket count and runnable flag
// and yields no result; slots at or beyond SLOTS are ignored. A draw item
// (tuser 1) yields one result: the winning slot, a found flag and the
// saturated ticket total. A draw makes a summing pass over the single read
// port of the ticket memory, one slot per cycle, then the bit-serial modulo,
// then a walk pass at the same rate that stops at the winner and is skipped
// when the total is zero. The runnable flags are flip-flops cleared by
// reset, so no clearing pass is needed. A finished result waits in an output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module lottery_slot_picker #(
    parameter int SLOTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // slot[5:0], runnable[6], ticket_count[16:7], random_draw[33:17], zeros
    input  logic [lsp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // chosen_slot[5:0], found[6], total_held[22:7], zeros
    output logic [lsp_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import lsp_pkg::*;

    lsp_cmd_t cmd;
    lsp_sts_t sts;

    // Sequencer.
    lsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Storage and arithmetic.
    lsp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule

FILE: rtl/lsp_datapath.sv
// ----------------------------------------------------------------------------
// Lottery slot picker datapath
// Ticket memory, runnable flags, ticket summing, serial modulo, winner walk
// and the result payload register.
// ----------------------------------------------------------------------------
module lsp_datapath #(
    parameter int SLOTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lsp_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  lsp_pkg::lsp_cmd_t                   cmd,
    output lsp_pkg::lsp_sts_t                   sts,
    output logic [lsp_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import lsp_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = IDX_W + 1;
    localparam int SUM_W = $clog2(SLOTS * ((1 << TIX_W) - 1) + 1);

    // Input fields.
    logic [SLOT_W-1:0] slot_in;
    logic              run_in;
    logic [TIX_W-1:0]  tix_in;
    logic [DRAW_W-1:0] draw_in;
    logic              in_range;
    logic [IDX_W-1:0]  waddr;

    assign slot_in  = s_tdata[IN_SLOT_LSB +: SLOT_W];
    assign run_in   = s_tdata[IN_RUN_LSB];
    assign tix_in   = s_tdata[IN_TIX_LSB +: TIX_W];
    assign draw_in  = s_tdata[IN_DRAW_LSB +: DRAW_W];
    assign in_range = (9'(slot_in) < 9'(SLOTS));
    assign waddr    = IDX_W'(slot_in);

    // Registers.
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pvld_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic [TIX_W-1:0]  rdata_reg;
    logic [SLOTS-1:0]  flags_reg, flags_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [DRAW_W-1:0] dq_reg, dq_next;
    logic [DCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [SUM_W-1:0]  run_reg, run_next;
    logic [IDX_W-1:0]  chosen_reg, chosen_next;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_found_reg;
    logic [TOT_W-1:0]  out_total_reg;

    logic [TIX_W-1:0]  mem [SLOTS];

    // Scan control and flag of the slot whose tickets are in the read register.
    logic              issue;
    logic              flag_p;
    assign issue  = (cmd.sum_en || cmd.walk_en) && (cnt_reg < CW'(SLOTS));
    assign flag_p = flags_reg[pidx_reg];

    // Restoring division step: remainder only.
    logic [SUM_W:0] trial;
    logic           trial_ge;
    assign trial    = {rem_reg, dq_reg[DRAW_W-1]};
    assign trial_ge = (trial >= {1'b0, acc_reg});

    // Walk compare against winner = remainder + 1.
    logic [SUM_W-1:0] winner;
    logic [SUM_W:0]   new_run;
    logic             hit;
    assign winner  = rem_reg + SUM_W'(1);
    assign new_run = (SUM_W+1)'(run_reg) + (SUM_W+1)'(rdata_reg);
    assign hit     = cmd.walk_en && pvld_reg && flag_p && (new_run >= (SUM_W+1)'(winner));

    // Saturated total for the result.
    logic [31:0]      acc_ext;
    logic [TOT_W-1:0] total_sat;
    assign acc_ext   = 32'(acc_reg);
    assign total_sat = (acc_ext > 32'd65535) ? {TOT_W{1'b1}} : acc_ext[TOT_W-1:0];

    // Status to the controller.
    assign sts.scan_done  = (cnt_reg == CW'(SLOTS)) && !pvld_reg;
    assign sts.total_zero = (acc_reg == '0);
    assign sts.div_last   = (bitcnt_reg == '0);
    assign sts.hit        = hit;

    // Next-state logic of the datapath registers.
    always_comb
    begin
        cnt_next    = cnt_reg;
        flags_next  = flags_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        bitcnt_next = bitcnt_reg;
        run_next    = run_reg;
        chosen_next = chosen_reg;

        if (cmd.start || cmd.walk_init)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        if (cmd.start)
        begin
            acc_next    = '0;
            dq_next     = draw_in;
            chosen_next = '0;
        end
        else if (cmd.sum_en && pvld_reg && flag_p)
        begin
            acc_next = acc_reg + SUM_W'(rdata_reg);
        end

        if (cmd.div_init)
        begin
            rem_next    = '0;
            bitcnt_next = DCNT_W'(DRAW_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_next    = trial_ge ? SUM_W'(trial - {1'b0, acc_reg}) : SUM_W'(trial);
            dq_next     = {dq_reg[DRAW_W-2:0], 1'b0};
            bitcnt_next = bitcnt_reg - DCNT_W'(1);
        end

        if (cmd.walk_init)
        begin
            run_next = '0;
        end
        else if (cmd.walk_en && pvld_reg && flag_p)
        begin
            run_next = SUM_W'(new_run);
        end

        if (cmd.upd_wr && in_range)
        begin
            flags_next[waddr] = run_in;
        end
        if (hit)
        begin
            flags_next[pidx_reg] = 1'b0;
            chosen_next          = pidx_reg;
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pvld_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            pvld_reg  <= issue;
            flags_reg <= flags_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pidx_reg   <= cnt_reg[IDX_W-1:0];
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        bitcnt_reg <= bitcnt_next;
        run_reg    <= run_next;
        chosen_reg <= chosen_next;
        if (cmd.out_load)
        begin
            out_slot_reg  <= SLOT_W'(chosen_reg);
            out_found_reg <= !sts.total_zero;
            out_total_reg <= total_sat;
        end
    end

    // Ticket memory: one write port for updates, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.upd_wr && in_range)
        begin
            mem[waddr] <= tix_in;
        end
        rdata_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    // Result packing.
    always_comb
    begin
        m_tdata = '0;
        m_tdata[OUT_SLOT_LSB +: SLOT_W] = out_slot_reg;
        m_tdata[OUT_FOUND_LSB]          = out_found_reg;
        m_tdata[OUT_TOT_LSB +: TOT_W]   = out_total_reg;
    end

    // A winning slot is no longer runnable afterwards.
    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> !flags_reg[$past(pidx_reg)])
        else $error("winning slot still runnable");

    // Before the crossing the running sum stays below the winner.
    a_run_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_en |-> (run_reg < winner))
        else $error("running sum passed winner without a pick");

    // The remainder stays below the total while dividing.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < acc_reg))
        else $error("remainder not below total");

endmodule

FILE: rtl/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// Lottery slot picker controller
// Sequences each draw through summing, modulo, walk (skipped when the total
// is zero) and result hand-off, and writes update items from idle.
// ----------------------------------------------------------------------------
module lsp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output lsp_pkg::lsp_cmd_t  cmd,
    input  lsp_pkg::lsp_sts_t  sts
);
    import lsp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // Sequencing of one item.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_UPDATE)
                    begin
                        cmd.upd_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.total_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once the item is taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // A draw item always starts the summing pass.
    a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == KIND_DRAW)) |=> (state_reg == S_SUM))
        else $error("draw item did not start summing");

    // With no runnable tickets the draw skips the walk.
    a_zero_skips: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && sts.total_zero) |=> (state_reg == S_DONE))
        else $error("empty draw entered the walk");

    // A loaded result is offered on the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid_reg)
        else $error("loaded result not offered");

endmodule
